// ===== rtl/core/oeal_pkg.sv =====
// ----------------------------------------------------------------------------
// oeal_pkg: shared types and constants
// Payload words, register codes and the command/status words of the shared
// multiply/divide unit.
// ----------------------------------------------------------------------------
package oeal_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] sample;
        logic [47:0]        stamp;
        logic               stamp_valid;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] filtered;
        logic               time_backwards;
    } out_word_t;

    localparam logic [1:0] REG_INITIAL_RATE = 2'd0;
    localparam logic [1:0] REG_MIN_CUTOFF   = 2'd1;
    localparam logic [1:0] REG_SPEED_GAIN   = 2'd2;
    localparam logic [1:0] REG_SLOPE_CUTOFF = 2'd3;

    localparam logic [31:0] RST_INITIAL_RATE = 32'd7864320;
    localparam logic [31:0] RST_MIN_CUTOFF   = 32'd65536;
    localparam logic [31:0] RST_SPEED_GAIN   = 32'd0;
    localparam logic [31:0] RST_SLOPE_CUTOFF = 32'd65536;

    // 2*pi in Q29
    localparam logic [47:0] TWO_PI_Q29 = 48'd3373259426;

    localparam logic       MODE_FILTER = 1'b0;
    localparam logic       MODE_CLEAR  = 1'b1;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic        done;
        logic [65:0] result;
    } arith_stat_t;

endpackage

// ===== rtl/core/one_euro_adaptive_lowpass.sv =====
// ----------------------------------------------------------------------------
// one_euro_adaptive_lowpass: adaptive low-pass filter, fixed point
// Speed-adaptive smoother for one sample stream with tick timestamps.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction | word
//  --------+---------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_data     | sink      | mode/sample/stamp
//  out     | out_valid, out_ready, out_data  | source    | filtered/backwards
//  cfg     | cfg_valid, cfg_ready, cfg_index,| sink      | register write
//          | cfg_data                        |           |
//
// One sample word runs, from accept to result, up to three 64-step divides
// and six shift-add multiplies, each multiply taking one step per multiplier
// bit up to its highest one, on one shared unit.
// A clear word (mode 1) clears the smoother state and gives no output word.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so a stalled out channel holds only the last step.
// cfg is always ready. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module one_euro_adaptive_lowpass #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int FRAC_BITS        = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  oeal_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output oeal_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import oeal_pkg::*;

    localparam logic [65:0] HALF_Q   = 66'd1 << (FRAC_BITS - 1);
    localparam logic [47:0] ONE_Q    = 48'd1 << FRAC_BITS;
    localparam logic [63:0] RATE_NUM = 64'(TICKS_PER_SECOND) << FRAC_BITS;
    localparam logic [65:0] W_ROUND  = 66'd1 << 28;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_SLOPE,
        S_SLOPE_MUL,
        S_SMOOTH,
        S_CUT,
        S_CUT_MUL,
        S_W_MUL,
        S_A_DIV,
        S_SM_MUL,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [31:0]        min_cutoff_reg;
    logic [31:0]        speed_gain_reg;
    logic [31:0]        slope_cutoff_reg;
    logic [31:0]        rate_reg;
    logic [47:0]        prev_stamp_reg;
    logic               prev_sv_reg;
    logic               have_value_reg;
    logic               have_slope_reg;
    logic signed [31:0] prev_raw_reg;
    logic signed [31:0] smooth_value_reg;
    logic signed [31:0] smooth_slope_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] slope_reg;
    logic               back_reg;
    logic               sel_reg;     // 0: slope smoother, 1: value smoother
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    arith_cmd_t         cmd_reg;
    logic [63:0]        opa_reg;
    logic [47:0]        opb_reg;
    arith_stat_t        stat;

    oeal_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_reg),
        .opa   (opa_reg),
        .opb   (opb_reg),
        .stat  (stat)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // timestamp step
    logic        stamp_upd;
    logic [47:0] gap;
    assign stamp_upd = prev_sv_reg && in_data.stamp_valid
                       && (in_data.stamp != prev_stamp_reg);
    assign gap = in_data.stamp - prev_stamp_reg;

    // raw difference for the slope
    logic signed [32:0] raw_diff;
    logic [32:0]        raw_mag;
    assign raw_diff = 33'(x_reg) - 33'(prev_raw_reg);
    assign raw_mag  = raw_diff[32] ? 33'(-raw_diff) : raw_diff;

    // rounded product >> FRAC_BITS
    logic [65:0] prod_q;
    assign prod_q = (stat.result + HALF_Q) >> FRAC_BITS;

    // slope saturation
    logic signed [31:0] slope_sat;
    always_comb
    begin
        if (raw_diff[32])
        begin
            slope_sat = (prod_q > 66'h80000000) ? 32'sh80000000 : -32'(prod_q[31:0]);
        end
        else
        begin
            slope_sat = (prod_q > 66'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(prod_q[31:0]);
        end
    end

    // smoother operands
    logic signed [31:0] sm_prev;
    logic signed [31:0] sm_x;
    logic signed [32:0] sm_diff;
    logic [32:0]        sm_mag;
    logic signed [33:0] sm_res;
    assign sm_prev = sel_reg ? smooth_value_reg : smooth_slope_reg;
    assign sm_x    = sel_reg ? x_reg : slope_reg;
    assign sm_diff = 33'(sm_x) - 33'(sm_prev);
    assign sm_mag  = sm_diff[32] ? 33'(-sm_diff) : sm_diff;
    assign sm_res  = sm_diff[32] ? 34'(sm_prev) - 34'(prod_q[32:0])
                                 : 34'(sm_prev) + 34'(prod_q[32:0]);

    // |smoothed slope|
    logic [31:0] ss_mag;
    assign ss_mag = smooth_slope_reg[31] ? 32'(-smooth_slope_reg) : 32'(smooth_slope_reg);

    // cutoff with saturation
    logic [65:0] cut_sum;
    logic [31:0] cut_sat;
    assign cut_sum = 66'(min_cutoff_reg) + prod_q;
    assign cut_sat = (cut_sum > 66'hFFFFFFFF) ? 32'hFFFFFFFF : cut_sum[31:0];

    // alpha denominator
    logic [65:0] w_full;
    logic [35:0] w_val;
    logic [36:0] den;
    assign w_full = (stat.result + W_ROUND) >> 29;
    assign w_val  = w_full[35:0];
    assign den    = 37'(w_val) + 37'(rate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            min_cutoff_reg   <= RST_MIN_CUTOFF;
            speed_gain_reg   <= RST_SPEED_GAIN;
            slope_cutoff_reg <= RST_SLOPE_CUTOFF;
            rate_reg         <= RST_INITIAL_RATE;
            prev_stamp_reg   <= '0;
            prev_sv_reg      <= 1'b0;
            have_value_reg   <= 1'b0;
            have_slope_reg   <= 1'b0;
            prev_raw_reg     <= '0;
            smooth_value_reg <= '0;
            smooth_slope_reg <= '0;
            out_valid_reg    <= 1'b0;
            cmd_reg          <= '{start: 1'b0, op: OP_MUL};
        end
        else
        begin
            // start is a one-cycle pulse; no op is issued while it is high
            if (cmd_reg.start)
            begin
                cmd_reg.start <= 1'b0;
            end

            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_INITIAL_RATE: rate_reg         <= cfg_data;
                    REG_MIN_CUTOFF:   min_cutoff_reg   <= cfg_data;
                    REG_SPEED_GAIN:   speed_gain_reg   <= cfg_data;
                    REG_SLOPE_CUTOFF: slope_cutoff_reg <= cfg_data;
                    default:          ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.mode == MODE_CLEAR)
                        begin
                            have_value_reg   <= 1'b0;
                            have_slope_reg   <= 1'b0;
                            prev_raw_reg     <= '0;
                            smooth_value_reg <= '0;
                            smooth_slope_reg <= '0;
                        end
                        else
                        begin
                            x_reg          <= in_data.sample;
                            prev_stamp_reg <= in_data.stamp;
                            prev_sv_reg    <= in_data.stamp_valid;
                            back_reg       <= stamp_upd && (in_data.stamp < prev_stamp_reg);
                            if (stamp_upd && (in_data.stamp > prev_stamp_reg))
                            begin
                                // rate = round(TPS << FRAC / gap)
                                cmd_reg   <= '{start: 1'b1, op: OP_DIV};
                                opa_reg   <= RATE_NUM + 64'(gap >> 1);
                                opb_reg   <= gap;
                                state_reg <= S_RATE;
                            end
                            else
                            begin
                                state_reg <= S_SLOPE;
                            end
                        end
                    end
                end
                S_RATE:
                begin
                    if (stat.done)
                    begin
                        rate_reg  <= (stat.result[65:32] != '0) ? 32'hFFFFFFFF
                                                                : stat.result[31:0];
                        state_reg <= S_SLOPE;
                    end
                end
                S_SLOPE:
                begin
                    if (have_value_reg)
                    begin
                        cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                        opa_reg   <= 64'(raw_mag);
                        opb_reg   <= 48'(rate_reg);
                        state_reg <= S_SLOPE_MUL;
                    end
                    else
                    begin
                        slope_reg <= x_reg;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SLOPE_MUL:
                begin
                    if (stat.done)
                    begin
                        slope_reg <= slope_sat;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH:
                begin
                    if (have_slope_reg)
                    begin
                        sel_reg   <= 1'b0;
                        cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                        opa_reg   <= 64'(slope_cutoff_reg);
                        opb_reg   <= TWO_PI_Q29;
                        state_reg <= S_W_MUL;
                    end
                    else
                    begin
                        // first slope passes straight through
                        smooth_slope_reg <= slope_reg;
                        have_slope_reg   <= 1'b1;
                        state_reg        <= S_CUT;
                    end
                end
                S_CUT:
                begin
                    cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                    opa_reg   <= 64'(speed_gain_reg);
                    opb_reg   <= 48'(ss_mag);
                    state_reg <= S_CUT_MUL;
                end
                S_CUT_MUL:
                begin
                    if (stat.done)
                    begin
                        if (have_value_reg)
                        begin
                            sel_reg   <= 1'b1;
                            cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                            opa_reg   <= 64'(cut_sat);
                            opb_reg   <= TWO_PI_Q29;
                            state_reg <= S_W_MUL;
                        end
                        else
                        begin
                            smooth_value_reg <= x_reg;
                            state_reg        <= S_DONE;
                        end
                    end
                end
                S_W_MUL:
                begin
                    if (stat.done)
                    begin
                        if (den == '0)
                        begin
                            // alpha = 1
                            cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                            opa_reg   <= 64'(sm_mag);
                            opb_reg   <= ONE_Q;
                            state_reg <= S_SM_MUL;
                        end
                        else
                        begin
                            cmd_reg   <= '{start: 1'b1, op: OP_DIV};
                            opa_reg   <= (64'(w_val) << FRAC_BITS) + 64'(den >> 1);
                            opb_reg   <= 48'(den);
                            state_reg <= S_A_DIV;
                        end
                    end
                end
                S_A_DIV:
                begin
                    if (stat.done)
                    begin
                        cmd_reg   <= '{start: 1'b1, op: OP_MUL};
                        opa_reg   <= 64'(sm_mag);
                        opb_reg   <= stat.result[47:0];
                        state_reg <= S_SM_MUL;
                    end
                end
                S_SM_MUL:
                begin
                    if (stat.done)
                    begin
                        if (sel_reg)
                        begin
                            smooth_value_reg <= sm_res[31:0];
                            state_reg        <= S_DONE;
                        end
                        else
                        begin
                            smooth_slope_reg <= sm_res[31:0];
                            have_slope_reg   <= 1'b1;
                            state_reg        <= S_CUT;
                        end
                    end
                end
                S_DONE:
                begin
                    // out_valid_reg is raised above on the same condition
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.filtered        <= smooth_value_reg;
                        out_data_reg.time_backwards  <= back_reg;
                        prev_raw_reg                 <= x_reg;
                        have_value_reg               <= 1'b1;
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/oeal_arith.sv =====
// ----------------------------------------------------------------------------
// oeal_arith: shared shift-add multiplier / restoring divider
// One step per cycle. Multiply ends when the multiplier runs out of ones;
// divide takes 64 steps for a 64-bit numerator.
// ----------------------------------------------------------------------------
module oeal_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oeal_pkg::arith_cmd_t cmd,
    input  logic [63:0]          opa,   // multiplicand or numerator
    input  logic [47:0]          opb,   // multiplier or divisor
    output oeal_pkg::arith_stat_t stat
);
    import oeal_pkg::*;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } astate_t;

    astate_t     state_reg;
    logic        done_reg;
    arith_op_t   op_reg;
    logic [65:0] acc_reg;
    logic [65:0] mcand_reg;
    logic [47:0] mplier_reg;
    logic [63:0] num_reg;
    logic [47:0] div_reg;
    logic [47:0] rem_reg;
    logic [5:0]  cnt_reg;

    logic [48:0] rem_sh;
    logic [49:0] trial;

    assign rem_sh = {rem_reg, num_reg[63]};
    assign trial  = {1'b0, rem_sh} - {2'b00, div_reg};

    assign stat.done   = done_reg;
    assign stat.result = (op_reg == OP_DIV) ? {2'b00, num_reg} : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            op_reg    <= OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (cmd.start)
                    begin
                        op_reg     <= cmd.op;
                        acc_reg    <= '0;
                        mcand_reg  <= {2'b00, opa};
                        mplier_reg <= opb;
                        num_reg    <= opa;
                        div_reg    <= opb;
                        rem_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= (cmd.op == OP_DIV) ? A_DIV : A_MUL;
                    end
                end
                A_MUL:
                begin
                    if (mplier_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_reg + mcand_reg;
                        end
                        mcand_reg  <= {mcand_reg[64:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[47:1]};
                    end
                end
                A_DIV:
                begin
                    if (!trial[49])
                    begin
                        rem_reg <= trial[47:0];
                        num_reg <= {num_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[47:0];
                        num_reg <= {num_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/one_euro_adaptive_lowpass_tb.sv =====
// ----------------------------------------------------------------------------
// one_euro_adaptive_lowpass_tb: self-checking bench for the adaptive filter
// Drives sample and clear words with random gaps, stalls the output side at
// random, and checks every output word against a bit-true predictor of the
// filter. Register settings are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module one_euro_adaptive_lowpass_tb;
    import oeal_pkg::*;

    // --- predictor + expected-word store ---
    class lowpass_scoreboard;
        bit [31:0] init_rate, min_cut, gain, slope_cut;
        bit [31:0] rate;
        bit [47:0] last_stamp;
        bit        last_stamp_ok, value_seen, slope_seen;
        longint    last_raw, value_acc, slope_acc;
        out_word_t pending[$];
        int        errors;

        function void clear_state();
            init_rate = RST_INITIAL_RATE;
            min_cut   = RST_MIN_CUTOFF;
            gain      = RST_SPEED_GAIN;
            slope_cut = RST_SLOPE_CUTOFF;
            rate = init_rate;
            last_stamp = '0;
            last_stamp_ok = 0;
            value_seen = 0;
            slope_seen = 0;
            last_raw = 0;
            value_acc = 0;
            slope_acc = 0;
        endfunction

        function void write_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                REG_INITIAL_RATE:
                begin
                    init_rate = v;
                    rate = v;
                end
                REG_MIN_CUTOFF:   min_cut = v;
                REG_SPEED_GAIN:   gain = v;
                REG_SLOPE_CUTOFF: slope_cut = v;
                default: ;
            endcase
        endfunction

        function bit [63:0] magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // smoothing factor, Q16, for a given cutoff at the current rate
        function bit [63:0] smoothing_gain(bit [31:0] cutoff);
            bit [95:0] w;
            bit [95:0] den;
            w = ({64'd0, cutoff} * 96'(TWO_PI_Q29) + (96'd1 << 28)) >> 29;
            den = w + rate;
            if (den == 0)
                return 64'd65536;
            return 64'(((w << 16) + den / 2) / den);
        endfunction

        function longint blend(longint prev, longint x, bit [63:0] a);
            longint    diff;
            bit [63:0] m;
            diff = x - prev;
            m = (magnitude(diff) * a + 64'd32768) >> 16;
            return (diff < 0) ? prev - longint'(m) : prev + longint'(m);
        endfunction

        function void note_input(in_word_t w);
            longint    x, slope, diff;
            bit [63:0] m, cut, gap, r;
            bit        back;
            out_word_t res;
            back = 0;
            if (w.mode == MODE_CLEAR)
            begin
                value_seen = 0;
                slope_seen = 0;
                last_raw = 0;
                value_acc = 0;
                slope_acc = 0;
                return;
            end
            x = longint'(w.sample);
            if (last_stamp_ok && w.stamp_valid && w.stamp != last_stamp)
            begin
                if (w.stamp < last_stamp)
                    back = 1;
                else
                begin
                    gap = w.stamp - last_stamp;
                    r = ((64'd1000000 << 16) + gap / 2) / gap;
                    rate = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
                end
            end
            last_stamp = w.stamp;
            last_stamp_ok = w.stamp_valid;
            if (value_seen)
            begin
                diff = x - last_raw;
                m = (magnitude(diff) * rate + 64'd32768) >> 16;
                if (diff < 0)
                    slope = (m > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
                else
                    slope = (m > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(m);
            end
            else
                slope = x;
            slope_acc = slope_seen ? blend(slope_acc, slope, smoothing_gain(slope_cut)) : slope;
            slope_seen = 1;
            cut = min_cut + ((gain * magnitude(slope_acc) + 64'd32768) >> 16);
            if (cut > 64'hFFFF_FFFF)
                cut = 64'hFFFF_FFFF;
            value_acc = value_seen ? blend(value_acc, x, smoothing_gain(cut[31:0])) : x;
            last_raw = x;
            value_seen = 1;
            res.filtered = value_acc[31:0];
            res.time_backwards = back;
            pending.push_back(res);
        endfunction

        function void check_output(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.filtered !== exp_w.filtered)
            begin
                $error("filtered: expected %0d, got %0d", exp_w.filtered, got.filtered);
                errors++;
            end
            if (got.time_backwards !== exp_w.time_backwards)
            begin
                $error("time_backwards: expected %0b, got %0b",
                       exp_w.time_backwards, got.time_backwards);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_word_t   out_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lowpass_scoreboard sb;
    bit          calm;      // no idling on either side while set
    bit [47:0]   tick;      // running timestamp for well-formed streams

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    one_euro_adaptive_lowpass i_dut (.*);

    // out side: random stall, check on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_output(out_data);
            out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // send one word; valid drops only in a gap or at drain, then hold
    // until accepted
    task automatic send_word(in_word_t w);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic write_cfg(logic [1:0] idx, bit [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // wait for all results, then cover the clear word still in flight
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic in_word_t make_sample(logic signed [31:0] s, bit [47:0] st, bit sv);
        in_word_t w;
        w.mode = MODE_FILTER;
        w.sample = s;
        w.stamp = st;
        w.stamp_valid = sv;
        return w;
    endfunction

    function automatic in_word_t clear_word();
        in_word_t w;
        w = '0;
        w.mode = MODE_CLEAR;
        w.sample = $urandom;
        w.stamp = 48'({$urandom, $urandom});
        w.stamp_valid = 1'($urandom_range(1));
        return w;
    endfunction

    // mostly a steady stream with forward ticks; some noise words
    task automatic random_phase(int count);
        in_word_t          w;
        logic signed [31:0] s;
        int                k;
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 2) && (i < count / 2 + 60);
            k = $urandom_range(99);
            s = $urandom_range(3) == 0 ? $urandom :
                $signed(32'($urandom_range(1 << 22))) - (1 << 21);
            if (k < 4)
                w = clear_word();
            else if (k < 8)
                w = make_sample(s, 48'({$urandom, $urandom}), 1'($urandom_range(1)));
            else if (k < 11)
                w = make_sample(s, tick - 48'($urandom_range(5000)), 1'b1);
            else
            begin
                tick = tick + 48'(k < 14 ? 0 : $urandom_range(20000, 1));
                if (k == 15)
                    tick = tick + {$urandom, 16'h0};
                w = make_sample(s, tick, k != 16);
            end
            send_word(w);
        end
        calm = 0;
    endtask

    initial
    begin
        #50_000_000;
        $display("** one_euro_adaptive_lowpass: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.clear_state();
        calm = 0;
        tick = 48'd1000;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, first sample pass-through, stamps
        send_word(make_sample(32'sh7FFF_FFFF, 48'd0, 1'b0));
        send_word(make_sample(-32'sh8000_0000, 48'd0, 1'b1));      // huge slope
        send_word(make_sample(32'sd0, 48'hFFFF_FFFF_FFFF, 1'b1));   // huge gap, rate -> 0
        send_word(make_sample(32'sd65536, 48'd5, 1'b1));            // backward step
        send_word(make_sample(32'sd65536, 48'd5, 1'b1));            // equal stamp
        send_word(make_sample(32'sd131072, 48'd6, 1'b1));           // 1 tick: rate saturates
        send_word(make_sample(-32'sd1, 48'd7, 1'b0));
        send_word(make_sample(32'sd4, 48'd10007, 1'b1));            // undefined prior stamp
        send_word(clear_word());
        send_word(make_sample(32'sd12345, 48'd20007, 1'b1));        // first after clear
        send_word(make_sample(32'sd23456, 48'd30007, 1'b1));
        send_word(make_sample(32'sh5555_AAAA, 48'hAAAA_5555_AAAA, 1'b1));
        send_word(make_sample(32'shAAAA_5555, 48'h5555_AAAA_5555, 1'b1));
        send_word(make_sample(32'sd100, 48'h5555_AAAA_5556, 1'b1));
        drain();

        // zero rate and extreme registers: both alpha terms at extremes
        write_cfg(REG_INITIAL_RATE, 32'd0);
        write_cfg(REG_MIN_CUTOFF, 32'hFFFF_FFFF);
        write_cfg(REG_SPEED_GAIN, 32'hFFFF_FFFF);
        write_cfg(REG_SLOPE_CUTOFF, 32'hFFFF_FFFF);
        send_word(clear_word());
        send_word(make_sample(32'sd70000, 48'd0, 1'b0));
        send_word(make_sample(-32'sd70000, 48'd0, 1'b0));
        send_word(make_sample(32'sh7FFF_FFFF, 48'd0, 1'b0));
        random_phase(250);
        drain();

        write_cfg(REG_INITIAL_RATE, 32'hFFFF_FFFF);
        write_cfg(REG_MIN_CUTOFF, 32'd1);
        write_cfg(REG_SPEED_GAIN, 32'd0);
        write_cfg(REG_SLOPE_CUTOFF, 32'd1);
        random_phase(400);
        drain();

        write_cfg(REG_INITIAL_RATE, RST_INITIAL_RATE);
        write_cfg(REG_MIN_CUTOFF, 32'd65536);
        write_cfg(REG_SPEED_GAIN, 32'd458);
        write_cfg(REG_SLOPE_CUTOFF, 32'd65536);
        random_phase(600);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_cfg(REG_INITIAL_RATE, $urandom_range(1 << 26, 1));
            write_cfg(REG_MIN_CUTOFF, $urandom_range(1 << 22, 1));
            write_cfg(REG_SPEED_GAIN, $urandom);
            write_cfg(REG_SLOPE_CUTOFF, $urandom);
            random_phase(160);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** one_euro_adaptive_lowpass: PASSED **");
        else
            $display("** one_euro_adaptive_lowpass: FAILED **");
        $finish;
    end

endmodule
